@@ src/meam_pkg.sv @@
// Shared types and codes for the mesh edge adjacency matcher.
package meam_pkg;

  localparam logic OP_BND = 1'b0;
  localparam logic OP_TRI = 1'b1;

  localparam logic [1:0] KIND_BND  = 2'd0;
  localparam logic [1:0] KIND_TRI  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_PAIR   = 3'd1;
  localparam logic [2:0] ST_BLINK  = 3'd2;
  localparam logic [2:0] ST_DUPB   = 3'd3;
  localparam logic [2:0] ST_OVER   = 3'd4;
  localparam logic [2:0] ST_FULL   = 3'd5;

  localparam logic [1:0] SIDE_MAX = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] idx;
    logic [1:0]  sd;
  } tag_t;

  // Query token travelling along the cell row.
  typedef struct packed {
    logic        valid;
    logic        resolved;
    logic        op;
    logic [31:0] key;
    logic [15:0] owner;
    logic [1:0]  side;
    logic [2:0]  status;
    logic [15:0] link_i;
    logic [1:0]  link_s;
    logic [15:0] part_e;
    logic [1:0]  part_s;
  } token_t;

endpackage

@@ src/meam_cell.sv @@
// One edge table slot: compares a passing query, inserts or updates, hands the query on.
module meam_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  meam_pkg::token_t tok_i,
  output meam_pkg::token_t tok_o,
  output logic            used_o
);
  import meam_pkg::*;

  logic        used_q, used_d;
  logic        vld_q;
  logic [31:0] key_q, key_d;
  tag_t        tag_q, tag_d;
  token_t      pl_q, tok_d;
  logic        hit;

  assign hit = used_q && (key_q == tok_i.key);

  always_comb begin
    used_d = used_q;
    key_d  = key_q;
    tag_d  = tag_q;
    tok_d  = tok_i;
    if (tok_i.valid && !tok_i.resolved) begin
      if (hit) begin
        tok_d.resolved = 1'b1;
        if (tok_i.op == OP_BND) begin
          tok_d.status = ST_DUPB;
        end else begin
          unique case (tag_q.kind)
            KIND_TRI: begin
              tok_d.status = ST_PAIR;
              tok_d.link_i = tag_q.idx;
              tok_d.link_s = tag_q.sd;
              tok_d.part_e = tag_q.idx;
              tok_d.part_s = tag_q.sd;
              tag_d.kind   = KIND_DONE;
            end
            KIND_BND: begin
              tok_d.status = ST_BLINK;
              tok_d.link_i = tag_q.idx;
            end
            default: begin
              tok_d.status = ST_OVER;
            end
          endcase
        end
      end else if (!used_q) begin
        // slots fill in order, so the first free slot ends the search
        tok_d.resolved = 1'b1;
        tok_d.status   = ST_STORED;
        used_d         = 1'b1;
        key_d          = tok_i.key;
        tag_d.kind     = (tok_i.op == OP_TRI) ? KIND_TRI : KIND_BND;
        tag_d.idx      = tok_i.owner;
        tag_d.sd       = tok_i.side;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      vld_q  <= 1'b0;
    end else if (en_i) begin
      used_q <= used_d;
      vld_q  <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= key_d;
      tag_q <= tag_d;
      pl_q  <= tok_d;
    end
  end

  always_comb begin
    tok_o       = pl_q;
    tok_o.valid = vld_q;
  end

  assign used_o = used_q;

endmodule

@@ src/mesh_edge_adjacency_matcher.sv @@
// Top level of the mesh edge adjacency matcher: input formatting, cell row, output register.
//
// Input channel (in_valid_i/in_ready_o) takes one edge occurrence per transaction:
// opcode, two vertex numbers, owner and side. The vertex pair is ordered into a
// 32-bit key and sent down a row of TABLE_ENTRIES cells, one cell per cycle unless stalled. Each
// cell holds one table slot; the first cell whose key matches resolves the query,
// and the first empty cell stores it. A query leaving the row unresolved reports
// table full.
// Output channel (out_valid_o/out_ready_i) gives exactly one result per transaction,
// in input order.
// Each query passes the register of every cell, then the output register, to out_valid_o.
// Throughput: one transaction per cycle while the receiver does not stall; queries follow
// each other down the row, so a later query always sees the slot updates of every earlier one.
// Reset clears all slot valid flags and the row at once; no clearing pass.
// A stalled receiver freezes the whole row and deasserts in_ready_o.
module mesh_edge_adjacency_matcher #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_TRIANGLES = 65536,
  parameter int MAX_BOUNDARY  = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [15:0] vertex_a_i,
  input  logic [15:0] vertex_b_i,
  input  logic [15:0] owner_i,
  input  logic [1:0]  side_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] this_element_o,
  output logic [1:0]  this_side_o,
  output logic [15:0] link_index_o,
  output logic [1:0]  link_side_o,
  output logic [15:0] partner_element_o,
  output logic [1:0]  partner_side_o
);
  import meam_pkg::*;

  localparam logic [16:0] BndLast = 17'(MAX_BOUNDARY - 1);
  localparam logic [16:0] TriLast = 17'(MAX_TRIANGLES - 1);

  logic                     advance;
  token_t                   chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] used;
  logic                     out_vld_q;
  token_t                   out_q;
  logic [15:0]              lo, hi;
  logic [16:0]              own_lim;

  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = advance;

  assign lo      = (vertex_a_i < vertex_b_i) ? vertex_a_i : vertex_b_i;
  assign hi      = (vertex_a_i < vertex_b_i) ? vertex_b_i : vertex_a_i;
  assign own_lim = (opcode_i == OP_BND) ? BndLast : TriLast;

  always_comb begin
    chain[0].valid    = in_valid_i && advance;
    chain[0].resolved = 1'b0;
    chain[0].op       = opcode_i;
    chain[0].key      = {lo, hi};
    chain[0].owner    = ({1'b0, owner_i} > own_lim) ? own_lim[15:0] : owner_i;
    if (opcode_i == OP_BND) begin
      chain[0].side = 2'd0;
    end else begin
      chain[0].side = (side_i > SIDE_MAX) ? SIDE_MAX : side_i;
    end
    // unresolved at the end of the row means no free slot
    chain[0].status = ST_FULL;
    chain[0].link_i = '0;
    chain[0].link_s = '0;
    chain[0].part_e = '0;
    chain[0].part_s = '0;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    meam_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1]),
      .used_o (used[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= chain[TABLE_ENTRIES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= chain[TABLE_ENTRIES];
    end
  end

  assign out_valid_o       = out_vld_q;
  assign status_o          = out_q.status;
  assign this_element_o    = out_q.owner;
  assign this_side_o       = out_q.side;
  assign link_index_o      = out_q.link_i;
  assign link_side_o       = out_q.link_s;
  assign partner_element_o = out_q.part_e;
  assign partner_side_o    = out_q.part_s;

  // slots are occupied from the front with no holes
  a_fill_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((used >> 1) & ~used) == '0)
    else $error("edge table has a hole");

  a_pair_links: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_PAIR |->
      link_index_o == partner_element_o && link_side_o == partner_side_o)
    else $error("neighbour pair link and partner differ");

  a_no_link_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_PAIR && status_o != ST_BLINK |->
      link_index_o == '0 && link_side_o == '0 && partner_element_o == '0 &&
      partner_side_o == '0)
    else $error("link fields set on a result without a link");

  a_blink_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BLINK |->
      link_side_o == '0 && partner_element_o == '0 && this_side_o <= SIDE_MAX)
    else $error("boundary link carries side or partner");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> used[TABLE_ENTRIES-1])
    else $error("table full reported with a free slot");

endmodule
